>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the smpd_checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/smpd_pkg.sv
// ----------------------------------------------------------------------------
// smpd_pkg
// types, constants and helpers of the serial mouse packet decoder
// ----------------------------------------------------------------------------
package smpd_pkg;

  localparam int BUTTON_COUNT = 3;
  localparam int EVENT_BITS   = BUTTON_COUNT + 1;  // one per button plus motion
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_MASK  = 8'hf8;
  localparam logic [7:0] HDR_VALUE = 8'h80;
  localparam logic [7:0] BTN_BITS  = 8'h07;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_MOTION  = 2'd2;

  // one decoded packet waiting to be turned into events
  typedef struct packed {
    logic [BUTTON_COUNT-1:0] change;
    logic [BUTTON_COUNT-1:0] pressed;
    logic                    motion;
    logic signed [8:0]       dx;
    logic signed [8:0]       dy;
  } pkt_rec_t;

  // header button bits are active low and reordered:
  // bit 0 -> button 2, bit 1 -> button 0, bit 2 -> button 1
  function automatic logic [2:0] btn_order(input logic [2:0] v);
    btn_order = {v[0], v[2], v[1]};
  endfunction

  function automatic logic signed [8:0] sext8(input logic [7:0] v);
    sext8 = $signed({v[7], v});
  endfunction

endpackage

>>> rtl/core/smpd_front.sv
// ----------------------------------------------------------------------------
// smpd_front
// header hunt, packet collection and decode into a packet record
// ----------------------------------------------------------------------------
module smpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable_we,
  input  logic              enable_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output smpd_pkg::pkt_rec_t q_rec
);
  import smpd_pkg::*;

  logic                    enable;
  logic [2:0]              pos;
  logic [2:0]              hdr_btn;
  logic [7:0]              x1;
  logic [7:0]              y1;
  logic [7:0]              x2;
  logic [BUTTON_COUNT-1:0] held;

  logic                    take;
  logic [2:0]              btn_all;
  logic [BUTTON_COUNT-1:0] pressed;
  logic signed [8:0]       dx;
  logic signed [8:0]       dy;
  logic                    last_byte;

  assign in_stall  = q_full;
  assign take      = in_valid && !in_stall && enable;
  assign last_byte = (pos == 3'd4);

  assign btn_all = btn_order(~hdr_btn & BTN_BITS[2:0]);
  assign pressed = btn_all[BUTTON_COUNT-1:0];
  assign dx      = sext8(x1) + sext8(x2);
  assign dy      = sext8(y1) + sext8(rx_byte);

  always_comb begin
    q_rec.change  = held ^ pressed;
    q_rec.pressed = pressed;
    q_rec.motion  = (dx != 9'sd0) || (dy != 9'sd0);
    q_rec.dx      = dx;
    q_rec.dy      = dy;
  end

  // empty packets make no record
  assign q_push = take && last_byte && ((q_rec.change != '0) || q_rec.motion);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      pos    <= 3'd0;
      held   <= '0;
    end else begin
      if (enable_we) begin
        enable <= enable_wdata;
      end
      if (take) begin
        case (pos)
          3'd1: begin
            x1  <= rx_byte;
            pos <= 3'd2;
          end
          3'd2: begin
            y1  <= rx_byte;
            pos <= 3'd3;
          end
          3'd3: begin
            x2  <= rx_byte;
            pos <= 3'd4;
          end
          3'd4: begin
            held <= pressed;
            pos  <= 3'd0;
          end
          default: begin
            // hunting for a header
            if ((rx_byte & HDR_MASK) == HDR_VALUE) begin
              hdr_btn <= rx_byte[2:0];
              pos     <= 3'd1;
            end else begin
              pos <= 3'd0;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/core/smpd_queue.sv
// ----------------------------------------------------------------------------
// smpd_queue
// short record queue between the front and back parts
// ----------------------------------------------------------------------------
module smpd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  smpd_pkg::pkt_rec_t wr_rec,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output smpd_pkg::pkt_rec_t head
);
  import smpd_pkg::*;

  pkt_rec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      bump = '0;
    end else begin
      bump = p + QPTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/smpd_back.sv
// ----------------------------------------------------------------------------
// smpd_back
// expands each packet record into button and motion events
// ----------------------------------------------------------------------------
module smpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  smpd_pkg::pkt_rec_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         event_kind,
  output logic [1:0]         button_index,
  output logic signed [8:0]  delta_x,
  output logic signed [8:0]  delta_y,
  output logic               last
);
  import smpd_pkg::*;

  logic [EVENT_BITS-1:0] done;
  logic [EVENT_BITS-1:0] pend;
  logic [EVENT_BITS-1:0] sel;
  logic [1:0]            sel_idx;
  logic                  slot_free;
  logic                  emit;
  logic                  sel_last;

  assign pend = {q_head.motion, q_head.change} & ~done;

  // lowest pending event first: buttons in index order, motion after them
  always_comb begin
    sel     = '0;
    sel_idx = '0;
    for (int i = EVENT_BITS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel     = '0;
        sel[i]  = 1'b1;
        sel_idx = 2'(i);
      end
    end
  end

  assign sel_last  = ((pend & ~sel) == '0);
  assign slot_free = !out_valid || !out_stall;
  assign emit      = q_nonempty && slot_free;
  assign q_pop     = emit && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (slot_free) begin
        out_valid <= q_nonempty;
      end
      if (emit) begin
        done <= sel_last ? '0 : (done | sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last <= sel_last;
      if (sel[EVENT_BITS-1]) begin
        event_kind   <= EV_MOTION;
        button_index <= 2'd0;
        delta_x      <= q_head.dx;
        delta_y      <= q_head.dy;
      end else begin
        event_kind   <= q_head.pressed[sel_idx[$clog2(BUTTON_COUNT+1)-1:0]] ?
                        EV_PRESS : EV_RELEASE;
        button_index <= sel_idx;
        delta_x      <= 9'sd0;
        delta_y      <= 9'sd0;
      end
    end
  end

endmodule

>>> rtl/core/serial_mouse_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder_unit
// five-byte serial mouse packet decoder, bytes in, button and motion events out
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with rx_byte, one received byte per
// transfer. a byte may be taken every cycle. with enable low every byte is
// taken and dropped.
// output channel: out_valid / out_stall with event_kind, button_index,
// delta_x, delta_y and last; last marks the final event of a packet.
// a packet's events come out one per cycle while out_stall is low; after the
// transfer of its fifth byte its record enters the queue, then the output register.
// a packet gives up to four events; the front keeps taking bytes while the
// back drains them, and in_stall rises only when the two-entry record queue
// is full, which the output stalling for long enough will cause.
// a stalled output holds its event until it is taken.
// reset clears enable, the header hunt, held buttons, the queue and the
// output register; enable_we / enable_wdata write the enable bit.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable_we,
  input  logic              enable_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic [1:0]        button_index,
  output logic signed [8:0] delta_x,
  output logic signed [8:0] delta_y,
  output logic              last
);
  import smpd_pkg::*;

  pkt_rec_t wr_rec;
  pkt_rec_t head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_nonempty;

  smpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .enable_we    (enable_we),
    .enable_wdata (enable_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (wr_rec)
  );

  smpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_rec   (wr_rec),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  smpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_head       (head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .button_index (button_index),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .last         (last)
  );

endmodule

>>> rtl/core/smpd_checker.sv
// ----------------------------------------------------------------------------
// smpd_checker
// port-level checks on the serial mouse packet decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smpd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        event_kind,
  input logic [1:0]        button_index,
  input logic signed [8:0] delta_x,
  input logic signed [8:0] delta_y,
  input logic              last
);
  import smpd_pkg::*;

  // nothing comes out right after reset
  `CHK_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !out_valid, "event valid after reset")

  // a stalled event holds
  `CHK_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(button_index) && $stable(delta_x) && $stable(delta_y) && $stable(last), "stalled event changed")

  // motion events carry a nonzero move and button zero
  `CHK_ASSERT(a_motion, clk, rst, out_valid && event_kind == EV_MOTION |-> button_index == 2'd0 && (delta_x != 9'sd0 || delta_y != 9'sd0), "bad motion event")

  // button events carry no motion and a button in range
  `CHK_ASSERT(a_button, clk, rst, out_valid && (event_kind == EV_PRESS || event_kind == EV_RELEASE) |-> delta_x == 9'sd0 && delta_y == 9'sd0 && button_index < 2'(BUTTON_COUNT), "bad button event")

  // motion is always the final event of its packet
  `CHK_ASSERT(a_motion_last, clk, rst, out_valid && event_kind == EV_MOTION |-> last, "motion event not last")

endmodule

bind serial_mouse_packet_decoder_unit smpd_checker u_smpd_checker (.*);

>>> verif/serial_mouse_packet_decoder_checker.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder_checker
// watches both channels of the mouse packet decoder, predicts its events from
// the accepted bytes and the enable bit, and compares every output transfer
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable_we,
  input  logic              enable_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        event_kind,
  input  logic [1:0]        button_index,
  input  logic signed [8:0] delta_x,
  input  logic signed [8:0] delta_y,
  input  logic              last,
  output int                fail_count,
  output int                expected_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import smpd_pkg::*;

  typedef struct {
    logic [1:0]        kind;
    logic [1:0]        button;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } mouse_event_t;

  mouse_event_t     mouse_events[$];
  logic             decode_enabled;
  logic [2:0]       packet_slot;
  logic [7:0]       header_byte;
  logic [7:0]       x1_byte;
  logic [7:0]       y1_byte;
  logic [7:0]       x2_byte;
  logic [2:0]       buttons_held;
  int               mismatches;

  // model of one received byte: hunt, collect, decode on the fifth
  task automatic decode_rx_byte(input logic [7:0] b);
    mouse_event_t      packet_events[$];
    mouse_event_t      ev;
    logic [2:0]        raw;
    logic [2:0]        down;
    logic signed [8:0] sum_x;
    logic signed [8:0] sum_y;
    if (!decode_enabled) begin
      return;
    end
    if (packet_slot == 3'd0) begin
      if ((b & HDR_MASK) == HDR_VALUE) begin
        header_byte = b;
        packet_slot = 3'd1;
      end
      return;
    end
    case (packet_slot)
      3'd1: x1_byte = b;
      3'd2: y1_byte = b;
      3'd3: x2_byte = b;
      default: ;
    endcase
    if (packet_slot != 3'd4) begin
      packet_slot = packet_slot + 3'd1;
      return;
    end
    packet_slot = 3'd0;
    // active low, header bit 1 is button 0, bit 2 button 1, bit 0 button 2
    raw  = ~header_byte[2:0];
    down = {raw[0], raw[2], raw[1]};
    for (int j = 0; j < 3; j++) begin
      if (down[j] != buttons_held[j]) begin
        ev.kind   = down[j] ? EV_PRESS : EV_RELEASE;
        ev.button = j[1:0];
        ev.dx     = '0;
        ev.dy     = '0;
        ev.last   = 1'b0;
        packet_events.push_back(ev);
      end
    end
    buttons_held = down;
    sum_x = $signed({x1_byte[7], x1_byte}) + $signed({x2_byte[7], x2_byte});
    sum_y = $signed({y1_byte[7], y1_byte}) + $signed({b[7], b});
    if (sum_x != 0 || sum_y != 0) begin
      ev.kind   = EV_MOTION;
      ev.button = 2'd0;
      ev.dx     = sum_x;
      ev.dy     = sum_y;
      ev.last   = 1'b0;
      packet_events.push_back(ev);
    end
    if (packet_events.size() > 0) begin
      packet_events[packet_events.size()-1].last = 1'b1;
    end
    foreach (packet_events[i]) begin
      mouse_events.push_back(packet_events[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input mouse_event_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kind %0d button %0d dx %0d dy %0d last %0d, got kind %0d button %0d dx %0d dy %0d last %0d",
               $realtime, what, want.kind, want.button, want.dx, want.dy, want.last,
               event_kind, button_index, delta_x, delta_y, last);
    end
  endtask

  always @(posedge clk) begin
    mouse_event_t want;
    if (rst) begin
      mouse_events.delete();
      decode_enabled = 1'b0;
      packet_slot    = 3'd0;
      buttons_held   = 3'd0;
      header_byte    = '0;
      x1_byte        = '0;
      y1_byte        = '0;
      x2_byte        = '0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_rx_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (mouse_events.size() == 0) begin
          want = '{default: '0};
          report_mismatch("event with nothing expected", want);
        end else begin
          want = mouse_events.pop_front();
          if (event_kind !== want.kind || button_index !== want.button ||
              delta_x !== want.dx || delta_y !== want.dy || last !== want.last) begin
            report_mismatch("event mismatch", want);
          end
        end
      end
      // the register takes effect after the edge it is written on
      if (enable_we) begin
        decode_enabled = enable_wdata;
      end
    end
    fail_count     <= mismatches;
    expected_count <= mouse_events.size();
  end

endmodule

>>> verif/tb_serial_mouse_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_serial_mouse_packet_decoder_unit
// drives received bytes and the enable bit into the mouse packet decoder under
// several idling and stalling mixes; a checker beside the block predicts and
// compares the events, and this module gives the verdict
// ----------------------------------------------------------------------------
module tb_serial_mouse_packet_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import smpd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 10;
  localparam int PHASE_ITEMS  = 70;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              enable_we = 1'b0;
  logic              enable_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        event_kind;
  logic [1:0]        button_index;
  logic signed [8:0] delta_x;
  logic signed [8:0] delta_y;
  logic              last;

  int fail_count;
  int expected_count;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int enabled_bytes;

  // extremes of both sums, full press and release, no-change packet,
  // header pattern taken as a motion byte
  logic [7:0] opening_bytes [22] = '{
    8'h00, 8'hff,
    8'h87, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
    8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h87, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h82, 8'h85, 8'h00, 8'h7b, 8'hff
  };

  always #5 clk = ~clk;

  serial_mouse_packet_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .enable_we    (enable_we),
    .enable_wdata (enable_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .button_index (button_index),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .last         (last)
  );

  serial_mouse_packet_decoder_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .enable_we      (enable_we),
    .enable_wdata   (enable_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .button_index   (button_index),
    .delta_x        (delta_x),
    .delta_y        (delta_y),
    .last           (last),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_mouse_packet_decoder_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // one byte transfer, with random idle cycles in front of it
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every predicted event has come out
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    enable_we    <= 1'b1;
    enable_wdata <= v;
    @(posedge clk);
    enable_we    <= 1'b0;
  endtask

  function automatic logic [7:0] motion_byte(input int style);
    logic [7:0] m;
    case (style)
      0: m = 8'h00;
      1: m = 8'($urandom_range(4)) - 8'd2;
      default: m = 8'($urandom_range(255));
    endcase
    return m;
  endfunction

  // well-formed packet with random buttons and motion, or a cut-short one
  task automatic send_packet(input int body_len);
    int style;
    style = $urandom_range(3);
    send_rx_byte(HDR_VALUE | 8'($urandom_range(7)));
    for (int i = 0; i < body_len; i++) begin
      send_rx_byte(motion_byte(style));
    end
    enabled_bytes += body_len + 1;
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: a header and a plain byte are dropped
    send_rx_byte(8'h80);
    send_rx_byte(8'h12);
    drain_events();
    write_enable(1'b1);
    foreach (opening_bytes[i]) begin
      send_rx_byte(opening_bytes[i]);
    end
    drain_events();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 67; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 67; end
        default: begin idle_pct = 16; stall_pct <= 16; end
      endcase
      // packet state must survive a spell with the decoder off
      write_enable(1'b0);
      repeat (4) send_rx_byte(8'($urandom_range(255)));
      drain_events();
      write_enable(1'b1);
      enabled_bytes = 0;
      while (enabled_bytes < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          send_rx_byte(8'($urandom_range(255)));
          enabled_bytes++;
        end else if (pick < 20) begin
          send_packet($urandom_range(1, 3));
        end else begin
          send_packet(4);
        end
      end
      drain_events();
    end

    if (fail_count == 0 && expected_count == 0) begin
      $display("serial_mouse_packet_decoder_unit test passed");
    end else begin
      $display("serial_mouse_packet_decoder_unit test failed");
    end
    $finish;
  end

endmodule
